[src/assert_macros.svh]
// assertion helpers, compiled out for synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, sampled on clk, off during reset
`define ASSERT_IMP(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed: implication");

// next-cycle implication, sampled on clk, off during reset
`define ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMP(lbl, pre, post)
`define ASSERT_NEXT(lbl, pre, post)

`endif

`endif

[src/blp_pkg.sv]
`default_nettype none

package blp_pkg;

    // input word codes
    localparam int MODE_W = 3;
    localparam logic [MODE_W-1:0] MODE_SIGHT  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_ASSIGN = 3'd1;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 3'd2;
    localparam logic [MODE_W-1:0] MODE_START  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_STOP   = 3'd4;

    // configuration register indexes
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_NEAR_RSSI = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_LAP   = 1'd1;

    localparam logic signed [7:0] NEAR_RSSI_RESET = -8'sd70;
    localparam logic [31:0]       MIN_LAP_RESET   = 32'd5000;

    // field widths
    localparam int SLOT_W = 4;
    localparam int ID_W   = 48;
    localparam int RSSI_W = 8;
    localparam int TIME_W = 32;
    localparam int CNT_W  = 32;

    // input tdata layout
    localparam int IN_SLOT_LSB = 0;
    localparam int IN_ID_LSB   = IN_SLOT_LSB + SLOT_W;
    localparam int IN_RSSI_LSB = IN_ID_LSB + ID_W;
    localparam int IN_TIME_LSB = IN_RSSI_LSB + RSSI_W;
    localparam int IN_DATA_W   = 96;
    localparam int IN_USER_W   = MODE_W;

    localparam int OUT_DATA_W = 112;
    localparam int OUT_USER_W = 2;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef struct packed {
        logic                     matched;
        logic                     lap_detected;
        logic [SLOT_W-1:0]        slot_out;
        logic [CNT_W-1:0]         laps;
        logic [TIME_W-1:0]        lap_time_ms;
        logic                     lap_time_valid;
        logic [TIME_W-1:0]        best_lap_ms;
        logic signed [RSSI_W-1:0] rssi_out;
    } blp_result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_CALC_A,
        ST_CALC_B,
        ST_EXEC,
        ST_EMIT
    } blp_state_t;

    typedef struct packed {
        logic take_in;     // latch the input word
        logic scan_start;  // rewind the slot scan
        logic scan_step;   // issue the next beacon read
        logic lap_read;    // capture the match and read its lap entry
        logic calc_a;      // time difference and operand capture
        logic calc_b;      // lap decision and write back
        logic exec;        // run a table or race command
        logic res_clear;   // all-zero result
        logic emit;        // move the result into the output register
    } blp_cmd_t;

    typedef struct packed {
        logic sight_go;    // live input is a sighting and a race runs
        logic hit;         // compared slot matches
        logic scan_last;   // compared slot is the last one
        logic out_free;    // output register can take a word
    } blp_status_t;

endpackage

`default_nettype wire

[src/blp_ram.sv]
`default_nettype none

module blp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[src/blp_ctrl.sv]
`default_nettype none

module blp_ctrl
    import blp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    output blp_cmd_t         cmd,
    input  wire blp_status_t status
);

    blp_state_t state_reg;
    blp_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        s_axis_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    cmd.take_in = 1'b1;
                    if (status.sight_go)
                    begin
                        cmd.scan_start = 1'b1;
                        state_next     = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_EXEC;
                    end
                end
            end
            ST_SCAN:
            begin
                priority if (status.hit)
                begin
                    cmd.lap_read = 1'b1;
                    state_next   = ST_CALC_A;
                end
                else if (status.scan_last)
                begin
                    cmd.res_clear = 1'b1;
                    state_next    = ST_EMIT;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            ST_CALC_A:
            begin
                cmd.calc_a = 1'b1;
                state_next = ST_CALC_B;
            end
            ST_CALC_B:
            begin
                cmd.calc_b = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EXEC:
            begin
                cmd.exec      = 1'b1;
                cmd.res_clear = 1'b1;
                state_next    = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[src/blp_datapath.sv]
`default_nettype none

module blp_datapath
    import blp_pkg::*;
#(
    parameter int TEAM_SLOTS = 16
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  wire logic [IN_USER_W-1:0]  s_axis_tuser,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic      [OUT_DATA_W-1:0] m_axis_tdata,
    output logic      [OUT_USER_W-1:0] m_axis_tuser,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire blp_cmd_t              cmd,
    output blp_status_t                status
);

    localparam int IDX_W = (TEAM_SLOTS > 1) ? $clog2(TEAM_SLOTS) : 1;
    localparam int EXT_W = IDX_W + SLOT_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TEAM_SLOTS - 1);
    localparam int LAP_W = TIME_W + CNT_W + TIME_W;

    // latched input word
    logic [MODE_W-1:0]        mode_reg;
    logic [SLOT_W-1:0]        slot_reg;
    logic [ID_W-1:0]          id_reg;
    logic signed [RSSI_W-1:0] rssi_reg;
    logic [TIME_W-1:0]        now_reg;

    logic signed [RSSI_W-1:0] thr_reg;
    logic [TIME_W-1:0]        min_lap_reg;

    logic                     race_reg;
    logic [TEAM_SLOTS-1:0]    valid_reg;
    logic [TEAM_SLOTS-1:0]    near_reg;
    logic [TEAM_SLOTS-1:0]    seen_reg;

    logic [IDX_W-1:0]         scan_addr_reg;
    logic [IDX_W-1:0]         cmp_idx_reg;
    logic                     cmp_vld_reg;
    logic [IDX_W-1:0]         match_idx_reg;

    logic [TIME_W-1:0]        diff_reg;
    logic [CNT_W-1:0]         total_reg;
    logic [TIME_W-1:0]        best_reg;
    logic                     seen_m_reg;
    logic                     was_reg;
    logic                     is_reg;

    blp_result_t              res_reg;
    blp_result_t              out_reg;
    logic                     out_valid_reg;

    logic [ID_W-1:0]          beacon_rd;
    logic [LAP_W-1:0]         lap_rd;
    logic [TIME_W-1:0]        rd_stamp;
    logic [CNT_W-1:0]         rd_total;
    logic [TIME_W-1:0]        rd_best;

    logic [EXT_W-1:0]         slot_ext;
    logic [EXT_W-1:0]         match_ext;
    logic [IDX_W-1:0]         slot_addr;
    logic                     slot_ok;
    logic                     beacon_we;

    logic                     gap_ok;
    logic                     lap;
    logic                     tvalid;
    logic [CNT_W-1:0]         total_new;
    logic [TIME_W-1:0]        best_new;

    assign slot_ext  = EXT_W'(slot_reg);
    assign slot_addr = slot_ext[IDX_W-1:0];
    assign slot_ok   = slot_ext < EXT_W'(TEAM_SLOTS);
    assign match_ext = EXT_W'(match_idx_reg);

    assign beacon_we = cmd.exec && (mode_reg == MODE_ASSIGN) && slot_ok;

    assign {rd_best, rd_total, rd_stamp} = lap_rd;

    // status toward the controller
    assign status.sight_go  = (s_axis_tuser == MODE_SIGHT) && race_reg;
    assign status.hit       = cmp_vld_reg && valid_reg[cmp_idx_reg] && (beacon_rd == id_reg);
    assign status.scan_last = cmp_vld_reg && (cmp_idx_reg == LAST_IDX);
    assign status.out_free  = !out_valid_reg || m_axis_tready;

    // lap decision, one compare each for the gap and the best lap
    always_comb
    begin
        gap_ok    = diff_reg >= min_lap_reg;
        lap       = !was_reg && is_reg && (!seen_m_reg || gap_ok);
        total_new = total_reg;
        if (lap && (total_reg != CNT_MAX))
        begin
            total_new = total_reg + CNT_W'(1);
        end
        // a seen slot already holds a lap, so the new count is above one
        tvalid   = lap && seen_m_reg;
        best_new = best_reg;
        if (tvalid && ((best_reg == '0) || (diff_reg < best_reg)))
        begin
            best_new = diff_reg;
        end
    end

    blp_ram #(
        .WIDTH (ID_W),
        .DEPTH (TEAM_SLOTS)
    ) u_beacon_ram (
        .clk   (clk),
        .we    (beacon_we),
        .waddr (slot_addr),
        .wdata (id_reg),
        .raddr (scan_addr_reg),
        .rdata (beacon_rd)
    );

    blp_ram #(
        .WIDTH (LAP_W),
        .DEPTH (TEAM_SLOTS)
    ) u_lap_ram (
        .clk   (clk),
        .we    (cmd.calc_b && lap),
        .waddr (match_idx_reg),
        .wdata ({best_new, total_new, now_reg}),
        .raddr (cmp_idx_reg),
        .rdata (lap_rd)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.take_in)
        begin
            mode_reg <= s_axis_tuser;
            slot_reg <= s_axis_tdata[IN_SLOT_LSB +: SLOT_W];
            id_reg   <= s_axis_tdata[IN_ID_LSB +: ID_W];
            rssi_reg <= s_axis_tdata[IN_RSSI_LSB +: RSSI_W];
            now_reg  <= s_axis_tdata[IN_TIME_LSB +: TIME_W];
        end
        if (cmd.calc_a)
        begin
            diff_reg   <= now_reg - rd_stamp;
            seen_m_reg <= seen_reg[match_idx_reg];
            was_reg    <= near_reg[match_idx_reg];
            is_reg     <= rssi_reg >= thr_reg;
            total_reg  <= seen_reg[match_idx_reg] ? rd_total : '0;
            best_reg   <= seen_reg[match_idx_reg] ? rd_best : '0;
        end
        if (cmd.res_clear)
        begin
            res_reg <= '0;
        end
        else if (cmd.calc_b)
        begin
            res_reg.matched        <= 1'b1;
            res_reg.lap_detected   <= lap;
            res_reg.slot_out       <= match_ext[SLOT_W-1:0];
            res_reg.laps           <= total_new;
            res_reg.lap_time_ms    <= tvalid ? diff_reg : '0;
            res_reg.lap_time_valid <= tvalid;
            res_reg.best_lap_ms    <= best_new;
            res_reg.rssi_out       <= rssi_reg;
        end
        if (cmd.emit)
        begin
            out_reg <= res_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg     <= NEAR_RSSI_RESET;
            min_lap_reg <= MIN_LAP_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_NEAR_RSSI: thr_reg     <= cfg_wdata[RSSI_W-1:0];
                CFG_MIN_LAP:   min_lap_reg <= cfg_wdata[TIME_W-1:0];
            endcase
        end
    end

    // slot flags and race state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            race_reg  <= 1'b0;
            valid_reg <= '0;
            near_reg  <= '0;
            seen_reg  <= '0;
        end
        else
        begin
            if (cmd.exec)
            begin
                unique case (mode_reg)
                    MODE_ASSIGN:
                    begin
                        if (slot_ok)
                        begin
                            if (!valid_reg[slot_addr])
                            begin
                                near_reg[slot_addr] <= 1'b0;
                                seen_reg[slot_addr] <= 1'b0;
                            end
                            valid_reg[slot_addr] <= 1'b1;
                        end
                    end
                    MODE_REMOVE:
                    begin
                        if (slot_ok)
                        begin
                            valid_reg[slot_addr] <= 1'b0;
                        end
                    end
                    MODE_START:
                    begin
                        race_reg <= 1'b1;
                        near_reg <= '0;
                        seen_reg <= '0;
                    end
                    MODE_STOP:
                    begin
                        race_reg <= 1'b0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.calc_b)
            begin
                near_reg[match_idx_reg] <= is_reg;
                if (lap)
                begin
                    seen_reg[match_idx_reg] <= 1'b1;
                end
            end
        end
    end

    // slot scan: read address runs one slot ahead of the compare
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_addr_reg <= '0;
            cmp_idx_reg   <= '0;
            cmp_vld_reg   <= 1'b0;
            match_idx_reg <= '0;
        end
        else
        begin
            if (cmd.scan_start)
            begin
                scan_addr_reg <= '0;
                cmp_vld_reg   <= 1'b0;
            end
            else if (cmd.scan_step)
            begin
                cmp_idx_reg <= scan_addr_reg;
                cmp_vld_reg <= 1'b1;
                if (scan_addr_reg != LAST_IDX)
                begin
                    scan_addr_reg <= scan_addr_reg + IDX_W'(1);
                end
            end
            if (cmd.lap_read)
            begin
                match_idx_reg <= cmp_idx_reg;
                cmp_vld_reg   <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000,
                            out_reg.rssi_out,
                            out_reg.best_lap_ms,
                            out_reg.lap_time_ms,
                            out_reg.laps,
                            out_reg.slot_out,
                            out_reg.lap_detected};
    assign m_axis_tuser  = {out_reg.lap_time_valid, out_reg.matched};

endmodule

`default_nettype wire

[src/beacon_lap_detector.sv]
// Beacon lap counter for a table of TEAM_SLOTS team slots. Every input word
// gives exactly one result word; table and race commands (assign, remove,
// start, stop), spare codes, sightings while no race runs and sightings that
// find no match give an all-zero result. A sighting while a race runs scans
// the beacon memory one slot per cycle over its single read port; on a match
// it reads the slot's lap entry, captures the operands and writes the lap
// update back. One word is worked on at a time; a finished result sits in
// the output register, so the next word is accepted while it waits. There
// is no clearing pass after reset.
`default_nettype none

`include "assert_macros.svh"

module beacon_lap_detector
    import blp_pkg::*;
#(
    parameter int TEAM_SLOTS = 16
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    // input words
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // team_slot[3:0], beacon_id[51:4], rssi[59:52], time_ms[91:60], zero fill
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    // mode[2:0]
    input  wire logic [IN_USER_W-1:0]  s_axis_tuser,

    // result words
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // lap_detected[0], slot_out[4:1], laps[36:5], lap_time_ms[68:37],
    // best_lap_ms[100:69], rssi_out[108:101], zero fill
    output logic      [OUT_DATA_W-1:0] m_axis_tdata,
    // matched[0], lap_time_valid[1]
    output logic      [OUT_USER_W-1:0] m_axis_tuser,

    // configuration writes: 0 near rssi threshold, 1 min lap time in ms
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    blp_cmd_t    cmd;
    blp_status_t status;

    // sequencer: scan, lap update and command execution
    blp_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .cmd           (cmd),
        .status        (status)
    );

    // slot memories, flags, lap arithmetic and the output register
    blp_datapath #(
        .TEAM_SLOTS (TEAM_SLOTS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .cmd           (cmd),
        .status        (status)
    );

    // one word in flight: no accept right after an accept
    `ASSERT_NEXT(a_one_in_flight, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    // a result never overwrites one that is still waiting
    `ASSERT_IMP(a_no_overwrite, cmd.emit, !m_axis_tvalid || m_axis_tready)
    // the lap update always follows its operand capture
    `ASSERT_IMP(a_calc_order, cmd.calc_b, $past(cmd.calc_a))

endmodule

`default_nettype wire

[tb/tb_beacon_lap_detector.sv]
module tb_beacon_lap_detector;
    import blp_pkg::*;

    // modes past stop are spare codes that the block ignores
    localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd5;
    localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

    localparam logic [ID_W-1:0] ID_A     = 48'h0123_4567_89AB;
    localparam logic [ID_W-1:0] ID_B     = 48'hFEDC_BA98_7654;
    localparam logic [ID_W-1:0] ID_STRAY = 48'h5555_5555_5555;
    localparam logic [ID_W-1:0] ID_ONES  = 48'hFFFF_FFFF_FFFF;

    localparam int POOL_SIZE = 6;
    localparam int TEAM_SLOTS_TB = 16;

    // one input word as the block sees it
    typedef struct packed {
        logic [MODE_W-1:0]        mode;
        logic [SLOT_W-1:0]        slot;
        logic [ID_W-1:0]          id;
        logic signed [RSSI_W-1:0] rssi;
        logic [TIME_W-1:0]        stamp;
    } beacon_word_t;

    typedef enum logic {ROW_WORD, ROW_REGS} row_kind_t;

    // one line of the directed script: a word to send or a register pair to write
    typedef struct {
        row_kind_t                kind;
        beacon_word_t             word;
        logic signed [RSSI_W-1:0] thr;
        logic [TIME_W-1:0]        floor_ms;
        bit                       pinned;
        blp_result_t              want;
    } plan_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [IN_USER_W-1:0]  s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [OUT_USER_W-1:0] m_axis_tuser;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // lap tracker mirror: registers, race flag and per-slot table
    logic signed [RSSI_W-1:0] m_near_thr;
    logic [TIME_W-1:0]        m_min_lap;
    logic                     m_racing;
    logic                     m_valid [TEAM_SLOTS_TB];
    logic [ID_W-1:0]          m_beacon [TEAM_SLOTS_TB];
    logic                     m_near [TEAM_SLOTS_TB];
    logic                     m_seen [TEAM_SLOTS_TB];
    logic [TIME_W-1:0]        m_last [TEAM_SLOTS_TB];
    logic [CNT_W-1:0]         m_laps [TEAM_SLOTS_TB];
    logic [TIME_W-1:0]        m_best [TEAM_SLOTS_TB];

    blp_result_t      lap_reports_due[$];
    plan_row_t        plan[$];
    logic [ID_W-1:0]  beacon_pool [POOL_SIZE];
    logic [TIME_W-1:0] clock_ms;
    int               words_in = 0;
    bit               calm = 1'b0;
    bit               failed = 1'b0;

    beacon_lap_detector #(
        .TEAM_SLOTS(TEAM_SLOTS_TB)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata)
    );

    always #1 clk = ~clk;

    // run-away guard, far beyond the slowest legal run
    initial
    begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // race-scoped lap state of one slot back to empty
    function automatic void wipe_slot(input int k);
        m_near[k] = 1'b0;
        m_seen[k] = 1'b0;
        m_laps[k] = '0;
        m_best[k] = '0;
    endfunction

    // apply one accepted word to the mirror and return the result word it yields
    function automatic blp_result_t score_word(input beacon_word_t w);
        blp_result_t      r;
        int               hit;
        logic             is_near;
        logic             lap;
        logic [TIME_W-1:0] dt;
        r = '0;
        hit = -1;
        case (w.mode)
            MODE_ASSIGN:
            begin
                if (!m_valid[w.slot])
                    wipe_slot(w.slot);
                m_valid[w.slot] = 1'b1;
                m_beacon[w.slot] = w.id;
            end
            MODE_REMOVE:
                m_valid[w.slot] = 1'b0;
            MODE_START:
            begin
                m_racing = 1'b1;
                for (int k = 0; k < TEAM_SLOTS_TB; k++)
                    wipe_slot(k);
            end
            MODE_STOP:
                m_racing = 1'b0;
            MODE_SIGHT:
            begin
                // lowest valid slot carrying this beacon wins
                if (m_racing)
                    for (int k = 0; k < TEAM_SLOTS_TB; k++)
                        if (hit < 0 && m_valid[k] && m_beacon[k] == w.id)
                            hit = k;
                if (hit >= 0)
                begin
                    is_near = (w.rssi >= m_near_thr);
                    dt = w.stamp - m_last[hit];
                    // far-to-near crossing, gated by the lap floor once a lap exists
                    lap = !m_near[hit] && is_near && (!m_seen[hit] || dt >= m_min_lap);
                    m_near[hit] = is_near;
                    if (lap)
                    begin
                        if (m_laps[hit] != CNT_MAX)
                            m_laps[hit]++;
                        if (m_laps[hit] > 1 && m_seen[hit])
                        begin
                            r.lap_time_ms = dt;
                            r.lap_time_valid = 1'b1;
                            // a stored best of zero still reads as no best yet
                            if (m_best[hit] == 0 || dt < m_best[hit])
                                m_best[hit] = dt;
                        end
                        m_last[hit] = w.stamp;
                        m_seen[hit] = 1'b1;
                    end
                    r.matched = 1'b1;
                    r.lap_detected = lap;
                    r.slot_out = 4'(hit);
                    r.laps = m_laps[hit];
                    r.best_lap_ms = m_best[hit];
                    r.rssi_out = w.rssi;
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    // directed script builders
    function automatic void add_word(input logic [MODE_W-1:0] mode, input int slot,
                                     input logic [ID_W-1:0] id, input int rssi,
                                     input logic [TIME_W-1:0] stamp);
        plan_row_t row;
        row = '{kind: ROW_WORD, word: '0, thr: '0, floor_ms: '0, pinned: 1'b0, want: '0};
        row.word.mode = mode;
        row.word.slot = 4'(slot);
        row.word.id = id;
        row.word.rssi = 8'(rssi);
        row.word.stamp = stamp;
        plan.insert(plan.size(), row);
    endfunction

    // fix the expected result of the last row by hand
    function automatic void pin_last(input blp_result_t r);
        plan[plan.size() - 1].pinned = 1'b1;
        plan[plan.size() - 1].want = r;
    endfunction

    function automatic void add_regs(input int thr, input logic [TIME_W-1:0] floor_ms);
        plan_row_t row;
        row = '{kind: ROW_REGS, word: '0, thr: 8'(thr), floor_ms: floor_ms,
                pinned: 1'b0, want: '0};
        plan.insert(plan.size(), row);
    endfunction

    function automatic logic [ID_W-1:0] any_id();
        return 48'({$urandom, $urandom});
    endfunction

    // rssi on the chosen side of the near threshold
    function automatic logic signed [RSSI_W-1:0] pick_rssi(input bit want_near);
        int lo;
        lo = int'(m_near_thr);
        if (want_near || lo == -128)
            return 8'(lo + $urandom_range(0, 127 - lo));
        return 8'(-128 + $urandom_range(0, lo + 127));
    endfunction

    // mostly sightings of pooled beacons on a moving clock, plus commands and noise
    function automatic beacon_word_t random_word();
        beacon_word_t w;
        int           pick;
        pick = $urandom_range(0, 99);
        w.mode = MODE_SIGHT;
        w.slot = 4'($urandom_range(0, 15));
        w.id = beacon_pool[$urandom_range(0, POOL_SIZE - 1)];
        w.rssi = 8'($urandom_range(0, 255));
        w.stamp = clock_ms;
        if (pick < 74)
        begin
            if (!m_racing && $urandom_range(0, 3) == 0)
                w.mode = MODE_START;
            else
            begin
                // steps small, about half a lap floor, about a floor, or anything
                case ($urandom_range(0, 3))
                    0: clock_ms += $urandom_range(0, 300);
                    1: clock_ms += m_min_lap / 2 - 20 + $urandom_range(0, 40);
                    2: clock_ms += m_min_lap - 10 + $urandom_range(0, 20);
                    default: clock_ms += $urandom;
                endcase
                w.stamp = clock_ms;
                w.rssi = pick_rssi($urandom_range(0, 1) == 1);
            end
        end
        else if (pick < 79)
            w.id = any_id();
        else if (pick < 87)
        begin
            w.mode = MODE_ASSIGN;
            if ($urandom_range(0, 3) == 0)
                w.id = any_id();
        end
        else if (pick < 91)
            w.mode = MODE_REMOVE;
        else if (pick < 94)
            w.mode = MODE_START;
        else if (pick < 95)
            w.mode = MODE_STOP;
        else if (pick < 98)
            w.mode = 3'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
        else
            w.stamp = $urandom;
        return w;
    endfunction

    // offer one word, optionally after an idle burst, and book its result at accept
    task automatic offer_word(input beacon_word_t w, input bit pinned,
                              input blp_result_t want);
        blp_result_t r;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= w.mode;
        s_axis_tdata  <= {4'b0, w.stamp, w.rssi, w.id, w.slot};
        do
            @(posedge clk);
        while (!s_axis_tready);
        r = score_word(w);
        lap_reports_due.insert(lap_reports_due.size(), pinned ? want : r);
        words_in++;
    endtask

    // every word yields a result, so an empty queue means the block is idle
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (lap_reports_due.size() != 0)
            @(posedge clk);
    endtask

    // write both registers on back-to-back edges
    task automatic program_regs(input logic signed [RSSI_W-1:0] thr,
                                input logic [TIME_W-1:0] floor_ms);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_NEAR_RSSI;
        cfg_wdata <= {24'h0, thr};
        @(posedge clk);
        cfg_index <= CFG_MIN_LAP;
        cfg_wdata <= floor_ms;
        @(posedge clk);
        cfg_we    <= 1'b0;
        m_near_thr = thr;
        m_min_lap  = floor_ms;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            failed = 1'b1;
        end
    endtask

    // result side: compare each accepted word with the oldest booked result
    always @(posedge clk)
    begin : result_check
        blp_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (lap_reports_due.size() == 0)
            begin
                $error("result word with nothing expected");
                failed = 1'b1;
            end
            else
            begin
                want = lap_reports_due.pop_front();
                check_field("matched", 32'(want.matched), 32'(m_axis_tuser[0]));
                check_field("lap_time_valid", 32'(want.lap_time_valid),
                            32'(m_axis_tuser[1]));
                check_field("lap_detected", 32'(want.lap_detected), 32'(m_axis_tdata[0]));
                check_field("slot_out", 32'(want.slot_out), 32'(m_axis_tdata[4:1]));
                check_field("laps", want.laps, m_axis_tdata[36:5]);
                check_field("lap_time_ms", want.lap_time_ms, m_axis_tdata[68:37]);
                check_field("best_lap_ms", want.best_lap_ms, m_axis_tdata[100:69]);
                check_field("rssi_out", 32'($unsigned(want.rssi_out)),
                            32'(m_axis_tdata[108:101]));
            end
        end
    end

    // receiver: random stall bursts, quiet stretches, one long hold-off that
    // backs the block up into its input, and no stalls in the calm tail
    initial
    begin : result_sink
        int  stall_left;
        int  quiet_left;
        int  pick;
        bit  held;
        stall_left = 0;
        quiet_left = 0;
        held = 1'b0;
        forever
        begin
            @(posedge clk);
            if (!held && words_in >= 150)
            begin
                held = 1'b1;
                stall_left = 250;
            end
            if (calm)
                m_axis_tready <= 1'b1;
            else if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else if (quiet_left > 0)
            begin
                quiet_left--;
                m_axis_tready <= 1'b1;
            end
            else
            begin
                pick = $urandom_range(0, 15);
                if (pick < 3)
                begin
                    stall_left = $urandom_range(0, 11);
                    m_axis_tready <= 1'b0;
                end
                else
                begin
                    if (pick == 3)
                        quiet_left = $urandom_range(20, 60);
                    m_axis_tready <= 1'b1;
                end
            end
        end
    end

    initial
    begin : stimulus
        beacon_word_t w;
        blp_result_t  first_lap;

        // mirror comes up as the block does after reset
        m_near_thr = NEAR_RSSI_RESET;
        m_min_lap  = MIN_LAP_RESET;
        m_racing   = 1'b0;
        for (int k = 0; k < TEAM_SLOTS_TB; k++)
        begin
            m_valid[k]  = 1'b0;
            m_beacon[k] = '0;
            m_last[k]   = '0;
            wipe_slot(k);
        end
        for (int k = 0; k < POOL_SIZE; k++)
            beacon_pool[k] = any_id();
        clock_ms = $urandom;

        first_lap = '{matched: 1'b1, lap_detected: 1'b1, slot_out: 4'd3, laps: 32'd1,
                      lap_time_ms: '0, lap_time_valid: 1'b0, best_lap_ms: '0,
                      rssi_out: 8'sd127};

        // directed script, reset register values first
        add_word(MODE_ASSIGN, 0, 48'h0, 0, 0);
        add_word(MODE_ASSIGN, 15, ID_ONES, 0, 0);
        add_word(MODE_ASSIGN, 3, ID_A, 0, 0);
        add_word(MODE_ASSIGN, 5, ID_A, 0, 0);
        // sighting while stopped changes nothing
        add_word(MODE_SIGHT, 0, ID_A, 127, 10);
        pin_last('0);
        add_word(MODE_START, 0, 48'h0, 0, 0);
        pin_last('0);
        // first crossing counts at once, on the lower of two slots with this beacon
        add_word(MODE_SIGHT, 0, ID_A, 127, 100);
        pin_last(first_lap);
        // one below threshold is far, at threshold is near but inside the floor
        add_word(MODE_SIGHT, 0, ID_A, -71, 200);
        add_word(MODE_SIGHT, 0, ID_A, -70, 1000);
        add_word(MODE_SIGHT, 0, ID_A, -128, 2000);
        // exactly the lap floor after the last lap
        add_word(MODE_SIGHT, 0, ID_A, 50, 5100);
        // lap time across the 32-bit clock wrap
        add_word(MODE_SIGHT, 0, ID_ONES, 127, 32'hFFFF_F000);
        add_word(MODE_SIGHT, 0, ID_ONES, -128, 32'hFFFF_F800);
        add_word(MODE_SIGHT, 0, ID_ONES, 127, 32'h0000_0A00);
        // unknown beacon during a race
        add_word(MODE_SIGHT, 0, ID_STRAY, 127, 12000);
        pin_last('0);
        // removing the lower slot hands the beacon to the next one
        add_word(MODE_REMOVE, 3, 48'h0, 0, 0);
        add_word(MODE_SIGHT, 0, ID_A, 127, 12500);
        // reassigning a live slot keeps its laps
        add_word(MODE_ASSIGN, 5, ID_B, 0, 0);
        add_word(MODE_SIGHT, 0, ID_B, -128, 13000);
        add_word(MODE_SPARE_HI, 5, ID_B, 127, 13100);
        pin_last('0);
        add_word(MODE_STOP, 0, 48'h0, 0, 0);
        pin_last('0);
        // zero floor: a zero lap time is stored but replaced by the next lap
        add_regs(0, 32'd0);
        add_word(MODE_START, 0, 48'h0, 0, 0);
        add_word(MODE_SIGHT, 0, ID_B, 10, 500);
        add_word(MODE_SIGHT, 0, ID_B, -1, 500);
        add_word(MODE_SIGHT, 0, ID_B, 0, 500);
        add_word(MODE_SIGHT, 0, ID_B, -5, 503);
        add_word(MODE_SIGHT, 0, ID_B, 5, 503);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[n])
        begin
            if (plan[n].kind == ROW_REGS)
            begin
                settle();
                program_regs(plan[n].thr, plan[n].floor_ms);
            end
            else
                offer_word(plan[n].word, plan[n].pinned, plan[n].want);
        end

        // random phases, each under its own register setting
        for (int ph = 0; ph < 5; ph++)
        begin
            settle();
            case (ph)
                0: program_regs(-8'sd128, 32'd0);
                1: program_regs(8'sd127, 32'hFFFF_FFFF);
                2: program_regs(8'($urandom_range(0, 255)), $urandom_range(0, 3000));
                3: program_regs(-8'sd60, $urandom);
                default: program_regs(8'($urandom_range(0, 255)), $urandom_range(100, 8000));
            endcase
            // last phase runs with no idling on either side
            if (ph == 4)
                calm = 1'b1;
            // seed the table with pooled beacons, then start a race
            for (int k = 0; k < POOL_SIZE; k++)
            begin
                w = '0;
                w.mode = MODE_ASSIGN;
                w.slot = 4'($urandom_range(0, 15));
                w.id = beacon_pool[k];
                offer_word(w, 1'b0, '0);
            end
            w = '0;
            w.mode = MODE_START;
            offer_word(w, 1'b0, '0);
            repeat (100)
                offer_word(random_word(), 1'b0, '0);
        end

        settle();
        // longest single word is well under this; catches stray results
        repeat (30) @(posedge clk);
        if (!failed)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

[sim.f]
+incdir+src
src/blp_pkg.sv
src/blp_ram.sv
src/blp_ctrl.sv
src/blp_datapath.sv
src/beacon_lap_detector.sv
tb/tb_beacon_lap_detector.sv
